// File: rtl/pipelined_isa_fetch_stage_unit_defines.svh
`ifndef PIPELINED_ISA_FETCH_STAGE_UNIT_DEFINES_SVH
`define PIPELINED_ISA_FETCH_STAGE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PIFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PIFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pifs_pkg.sv
`timescale 1ns / 1ps

package pifs_pkg;

   // Instruction memory size in bytes, a power of two.
   localparam int MEM_BYTES   = 4096;
   // The memory is split into byte-wide banks so that one fetch window is read at once.
   localparam int BANKS       = 16;
   localparam int BANK_W      = $clog2(BANKS);
   localparam int ROWS        = MEM_BYTES / BANKS;
   localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
   // Opcode byte, register byte and an eight-byte constant.
   localparam int FETCH_BYTES = 10;
   localparam int LOAD_ADDR_W = 12;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   localparam logic [3:0] OP_HALT   = 4'd0;
   localparam logic [3:0] OP_NOP    = 4'd1;
   localparam logic [3:0] OP_RRMOVQ = 4'd2;
   localparam logic [3:0] OP_IRMOVQ = 4'd3;
   localparam logic [3:0] OP_RMMOVQ = 4'd4;
   localparam logic [3:0] OP_MRMOVQ = 4'd5;
   localparam logic [3:0] OP_OPQ    = 4'd6;
   localparam logic [3:0] OP_JXX    = 4'd7;
   localparam logic [3:0] OP_CALL   = 4'd8;
   localparam logic [3:0] OP_RET    = 4'd9;
   localparam logic [3:0] OP_PUSHQ  = 4'd10;
   localparam logic [3:0] OP_POPQ   = 4'd11;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_HALT = 2'd1;
   localparam logic [1:0] ST_ADR  = 2'd2;
   localparam logic [1:0] ST_INS  = 2'd3;

   localparam logic [3:0] NO_REG = 4'd15;

   typedef struct packed {
      logic        cmd;
      logic [19:0] load_entry;
      logic [3:0]  mem_stage_opcode;
      logic        mem_stage_cond;
      logic [63:0] mem_stage_fallthrough;
      logic [3:0]  wb_stage_opcode;
      logic [63:0] wb_stage_loaded;
      logic [3:0]  ex_stage_opcode;
      logic [3:0]  ex_stage_load_dest;
      logic        ex_stage_cond;
      logic [3:0]  dec_src_first;
      logic [3:0]  dec_src_second;
   } req_word_type;

   typedef struct packed {
      logic [63:0] fetch_addr;
      logic [1:0]  dreg_status;
      logic [3:0]  dreg_opcode;
      logic [3:0]  dreg_func;
      logic [3:0]  dreg_reg_a;
      logic [3:0]  dreg_reg_b;
      logic [63:0] dreg_constant;
      logic [63:0] dreg_next_pc;
      logic        fetch_stall;
      logic        decode_stall;
      logic        decode_bubble;
   } rsp_word_type;

   // Decoded instruction handed from the decoder to the stage control.
   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  opcode;
      logic [3:0]  func;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [63:0] constant;
      logic [63:0] next_pc;
      logic [63:0] pred_pc;
   } fetch_info_type;

endpackage

// File: rtl/pifs_ram.sv
`timescale 1ns / 1ps

module pifs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pifs_decode.sv
`timescale 1ns / 1ps

module pifs_decode (
   input  logic [63:0]                              fetch_pc,
   input  logic [pifs_pkg::BANKS-1:0][7:0]          bank_q,
   output pifs_pkg::fetch_info_type                 info
);

   logic [pifs_pkg::FETCH_BYTES-1:0][7:0] fbyte;
   logic [pifs_pkg::FETCH_BYTES-1:0]      oob;
   logic [3:0]                            op;
   logic [3:0]                            fn;
   logic                                  need_regs;
   logic                                  need_const;
   logic                                  const_oob;
   logic                                  err;
   logic [63:0]                           valc;
   logic [63:0]                           valp;
   logic [3:0]                            ilen;

   // Byte i of the window sits in bank (pc + i) mod BANKS; bytes beyond memory read as zero.
   for (genvar gi = 0; gi < pifs_pkg::FETCH_BYTES; gi++) begin : g_byte
      logic [63:0] addr;
      assign addr      = fetch_pc + 64'(gi);
      assign oob[gi]   = addr >= 64'(pifs_pkg::MEM_BYTES);
      assign fbyte[gi] = oob[gi] ? 8'h00 : bank_q[addr[pifs_pkg::BANK_W-1:0]];
   end

   always_comb begin
      op = fbyte[0][7:4];
      fn = fbyte[0][3:0];
      need_regs = op inside {pifs_pkg::OP_RRMOVQ, pifs_pkg::OP_IRMOVQ, pifs_pkg::OP_RMMOVQ,
                             pifs_pkg::OP_MRMOVQ, pifs_pkg::OP_OPQ, pifs_pkg::OP_PUSHQ,
                             pifs_pkg::OP_POPQ};
      need_const = op inside {pifs_pkg::OP_IRMOVQ, pifs_pkg::OP_RMMOVQ, pifs_pkg::OP_MRMOVQ,
                              pifs_pkg::OP_JXX, pifs_pkg::OP_CALL};

      // The constant follows the register byte when there is one.
      if (need_regs) begin
         valc      = 64'(fbyte[9:2]);
         const_oob = |oob[9:2];
      end else begin
         valc      = 64'(fbyte[8:1]);
         const_oob = |oob[8:1];
      end
      if (!need_const) begin
         valc = '0;
      end

      err  = oob[0] | (need_regs & oob[1]) | (need_const & const_oob);
      ilen = 4'd1 + {3'b000, need_regs} + {need_const, 3'b000};
      valp = fetch_pc + 64'(ilen);

      info.reg_a    = need_regs ? fbyte[1][7:4] : pifs_pkg::NO_REG;
      info.reg_b    = need_regs ? fbyte[1][3:0] : pifs_pkg::NO_REG;
      info.constant = valc;
      info.next_pc  = valp;
      info.pred_pc  = (op == pifs_pkg::OP_JXX || op == pifs_pkg::OP_CALL) ? valc : valp;

      // Address error outranks an invalid opcode, which outranks halt.
      info.opcode = op;
      info.func   = fn;
      if (err) begin
         info.status = pifs_pkg::ST_ADR;
         info.opcode = pifs_pkg::OP_NOP;
         info.func   = 4'd0;
      end else if (op > pifs_pkg::OP_POPQ) begin
         info.status = pifs_pkg::ST_INS;
      end else if (op == pifs_pkg::OP_HALT) begin
         info.status = pifs_pkg::ST_HALT;
      end else begin
         info.status = pifs_pkg::ST_OK;
      end
   end

endmodule

// File: rtl/pipelined_isa_fetch_stage_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                          Word type                 Direction
// request   req_valid req_ready req_data   pifs_pkg::req_word_type   in
// response  rsp_valid rsp_ready rsp_data   pifs_pkg::rsp_word_type   out
//
// One request word is taken per cycle while req_ready is high. A fetch word's response
// word is loaded from the stage register once the response register is empty or drained;
// a load word gives none and only writes a byte. The loop that sets the rate runs from
// the bank read registers through the decoder and the next-PC select back to the bank
// read addresses, all combinational. After reset the sixteen byte banks are cleared one
// row per cycle, MEM_BYTES / 16 = 256 rows; req_ready stays low for that time.
// A held response stalls the fetch stage register, and then req_ready drops.

module pipelined_isa_fetch_stage_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pifs_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pifs_pkg::rsp_word_type rsp_data
);

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  opcode;
      logic [3:0]  func;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [63:0] constant;
      logic [63:0] next_pc;
   } dec_word_type;

   localparam dec_word_type DEC_NOP = '{
      status:   pifs_pkg::ST_OK,
      opcode:   pifs_pkg::OP_NOP,
      func:     4'd0,
      reg_a:    pifs_pkg::NO_REG,
      reg_b:    pifs_pkg::NO_REG,
      constant: 64'd0,
      next_pc:  64'd0
   };

   // Handshake and control.
   logic                                 accept;
   logic                                 is_fetch;
   logic                                 s1_go;
   logic [63:0]                          pc_base;
   logic [63:0]                          fetch_pc;
   logic                                 load_use;
   logic                                 bubble;
   logic [pifs_pkg::LOAD_ADDR_W-1:0]     load_addr;
   logic [63:0]                          load_addr_wide;
   logic                                 load_wr;

   // Memory ports.
   logic [pifs_pkg::BANKS-1:0]           bank_wr_en;
   logic [pifs_pkg::ROW_W-1:0]           bank_wr_row;
   logic [7:0]                           bank_wr_data;
   logic [pifs_pkg::BANKS-1:0][7:0]      bank_q;
   pifs_pkg::fetch_info_type             info;

   // Registers.
   logic                                 clr_busy_ff, clr_busy_in;
   logic [pifs_pkg::ROW_W-1:0]           clr_row_ff, clr_row_in;
   logic [63:0]                          predicted_pc_ff, predicted_pc_in;
   logic                                 s1_valid_ff, s1_valid_in;
   logic [63:0]                          s1_pc_ff, s1_pc_in;
   logic                                 s1_load_use_ff, s1_load_use_in;
   logic                                 s1_bubble_ff, s1_bubble_in;
   dec_word_type                         dec_ff, dec_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   pifs_pkg::rsp_word_type               rsp_data_ff, rsp_data_in;

   // The stage register moves on when the response register is empty or being drained.
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_go);
   assign accept    = req_valid && req_ready;
   assign is_fetch  = req_data.cmd == pifs_pkg::CMD_FETCH;

   always_comb begin
      // The word in the stage register updates the predicted PC at this same edge, so
      // its prediction is forwarded to the word being accepted now.
      if (s1_valid_ff && !s1_load_use_ff) begin
         pc_base = info.pred_pc;
      end else begin
         pc_base = predicted_pc_ff;
      end

      // A mispredicted jump's fall-through wins over a return address, which wins over
      // the prediction.
      if (req_data.mem_stage_opcode == pifs_pkg::OP_JXX && !req_data.mem_stage_cond) begin
         fetch_pc = req_data.mem_stage_fallthrough;
      end else if (req_data.wb_stage_opcode == pifs_pkg::OP_RET) begin
         fetch_pc = req_data.wb_stage_loaded;
      end else begin
         fetch_pc = pc_base;
      end

      // Load-use compares even against the "no register" id, as the pipeline control does.
      load_use = (req_data.ex_stage_opcode == pifs_pkg::OP_MRMOVQ ||
                  req_data.ex_stage_opcode == pifs_pkg::OP_POPQ) &&
                 (req_data.ex_stage_load_dest == req_data.dec_src_first ||
                  req_data.ex_stage_load_dest == req_data.dec_src_second);
      bubble   = req_data.ex_stage_opcode == pifs_pkg::OP_JXX && !req_data.ex_stage_cond;

      // Byte loads beyond the memory are dropped.
      load_addr      = req_data.load_entry[19:8];
      load_addr_wide = 64'(load_addr);
      load_wr        = accept && !is_fetch && (load_addr_wide < 64'(pifs_pkg::MEM_BYTES));

      // Write port: the clearing pass writes every bank of one row, a load writes one bank.
      if (clr_busy_ff) begin
         bank_wr_en   = '1;
         bank_wr_row  = clr_row_ff;
         bank_wr_data = 8'h00;
      end else begin
         bank_wr_en   = '0;
         bank_wr_row  = load_addr_wide[pifs_pkg::ROW_W+pifs_pkg::BANK_W-1:pifs_pkg::BANK_W];
         bank_wr_data = req_data.load_entry[7:0];
         if (load_wr) begin
            bank_wr_en[load_addr_wide[pifs_pkg::BANK_W-1:0]] = 1'b1;
         end
      end
   end

   // Each bank holds the bytes whose low address bits equal its index. A bank whose index
   // is below the PC's low bits supplies a byte from the following row.
   for (genvar gb = 0; gb < pifs_pkg::BANKS; gb++) begin : g_bank
      logic [pifs_pkg::ROW_W-1:0] rd_row;
      assign rd_row = fetch_pc[pifs_pkg::ROW_W+pifs_pkg::BANK_W-1:pifs_pkg::BANK_W] +
                      pifs_pkg::ROW_W'(pifs_pkg::BANK_W'(gb) < fetch_pc[pifs_pkg::BANK_W-1:0]);

      pifs_ram #(
         .WIDTH (8),
         .DEPTH (pifs_pkg::ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_wr_en[gb]),
         .wr_addr (bank_wr_row),
         .wr_data (bank_wr_data),
         .rd_en   (accept && is_fetch),
         .rd_addr (rd_row),
         .rd_data (bank_q[gb])
      );
   end

   pifs_decode u_decode (
      .fetch_pc (s1_pc_ff),
      .bank_q   (bank_q),
      .info     (info)
   );

   always_comb begin
      clr_busy_in = clr_busy_ff && (clr_row_ff != pifs_pkg::ROW_W'(pifs_pkg::ROWS - 1));
      clr_row_in  = clr_busy_ff ? clr_row_ff + pifs_pkg::ROW_W'(1) : clr_row_ff;

      // Stage register: a fetch word waits here while its bytes come out of the banks.
      if (accept) begin
         s1_valid_in = is_fetch;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s1_pc_in       = accept ? fetch_pc : s1_pc_ff;
      s1_load_use_in = accept ? load_use : s1_load_use_ff;
      s1_bubble_in   = accept ? bubble : s1_bubble_ff;

      predicted_pc_in = (s1_go && !s1_load_use_ff) ? info.pred_pc : predicted_pc_ff;

      // Decode register: held on a load-use stall, loaded with a nop on a bubble; the
      // bubble wins when both are raised.
      dec_in = dec_ff;
      if (s1_go) begin
         if (!s1_load_use_ff) begin
            dec_in = '{
               status:   info.status,
               opcode:   info.opcode,
               func:     info.func,
               reg_a:    info.reg_a,
               reg_b:    info.reg_b,
               constant: info.constant,
               next_pc:  info.next_pc
            };
         end
         if (s1_bubble_ff) begin
            dec_in = DEC_NOP;
         end
      end

      // Response register reports the decode register as it stands after the update.
      if (s1_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{
            fetch_addr:    s1_pc_ff,
            dreg_status:   dec_in.status,
            dreg_opcode:   dec_in.opcode,
            dreg_func:     dec_in.func,
            dreg_reg_a:    dec_in.reg_a,
            dreg_reg_b:    dec_in.reg_b,
            dreg_constant: dec_in.constant,
            dreg_next_pc:  dec_in.next_pc,
            fetch_stall:   s1_load_use_ff,
            decode_stall:  s1_load_use_ff,
            decode_bubble: s1_bubble_ff
         };
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff     <= 1'b1;
         clr_row_ff      <= '0;
         predicted_pc_ff <= 64'd0;
         s1_valid_ff     <= 1'b0;
         dec_ff          <= DEC_NOP;
         rsp_valid_ff    <= 1'b0;
      end else begin
         clr_busy_ff     <= clr_busy_in;
         clr_row_ff      <= clr_row_in;
         predicted_pc_ff <= predicted_pc_in;
         s1_valid_ff     <= s1_valid_in;
         dec_ff          <= dec_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pc_ff       <= s1_pc_in;
      s1_load_use_ff <= s1_load_use_in;
      s1_bubble_ff   <= s1_bubble_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/pifs_checker.sv
`timescale 1ns / 1ps
`include "pipelined_isa_fetch_stage_unit_defines.svh"

module pifs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pifs_pkg::rsp_word_type rsp_data
);

   // A response that is not taken stays put.
   `PIFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

   // The load-use hazard stalls fetch and decode together.
   `PIFS_ASSERT_NOW(a_stall_pair, clock, reset, rsp_valid, rsp_data.fetch_stall == rsp_data.decode_stall, "fetch and decode stall disagree")

   // A bubble leaves a clean nop in decode.
   `PIFS_ASSERT_NOW(a_bubble_nop, clock, reset, rsp_valid && rsp_data.decode_bubble, rsp_data.dreg_opcode == pifs_pkg::OP_NOP && rsp_data.dreg_status == pifs_pkg::ST_OK && rsp_data.dreg_reg_a == pifs_pkg::NO_REG && rsp_data.dreg_reg_b == pifs_pkg::NO_REG && rsp_data.dreg_constant == 64'd0 && rsp_data.dreg_next_pc == 64'd0, "bubble did not insert a nop")

   // An address error turns the instruction into a nop with function zero.
   `PIFS_ASSERT_NOW(a_adr_nop, clock, reset, rsp_valid && rsp_data.dreg_status == pifs_pkg::ST_ADR, rsp_data.dreg_opcode == pifs_pkg::OP_NOP && rsp_data.dreg_func == 4'd0, "address error kept its opcode")

endmodule

bind pipelined_isa_fetch_stage_unit pifs_checker u_pifs_checker (.*);

// File: sim/tb_pipelined_isa_fetch_stage_unit.sv
`timescale 1ns / 1ps

module tb_pipelined_isa_fetch_stage_unit;
   import pifs_pkg::*;

   // Total request words offered, directed rows included.
   localparam int TOTAL_WORDS = 1670;
   // Words after which the receiver starts its long hold-off.
   localparam int HOLD_AT = 700;
   // Words after which the sender waits for every outstanding fetch.
   localparam int DRAIN_AT = 1100;
   // Words after which neither side idles any more.
   localparam int QUIET_AT = 1450;
   localparam int LONG_HOLD = 300;
   // The limit leaves room for the slowest correct run: every word with the longest sender
   // gap and the longest response stall, plus the bank clear after reset and the long hold-off.
   localparam int CYCLE_LIMIT = 400000;

   // Decode register contents after reset and after a bubble.
   localparam fetch_info_type NOP_DECODE =
      '{ST_OK, OP_NOP, 4'd0, NO_REG, NO_REG, 64'd0, 64'd0, 64'd0};

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type fixed;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   // Shadow of the fetch stage: instruction memory, predicted PC and decode register.
   logic [7:0]     image_mem [MEM_BYTES];
   logic [63:0]    next_fetch_pc;
   fetch_info_type decode_reg;

   // Decode words predicted for accepted fetch words, oldest first.
   rsp_word_type   predicted_decodes [$];
   // Start addresses of the instructions of the program that was written last.
   logic [63:0]    program_entries [$];
   directed_row_type directed_rows [$];

   int  sent_count = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  quiet_tail = 1'b0;
   bit  long_hold = 1'b0;
   rsp_word_type oldest;

   pipelined_isa_fetch_stage_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit has_reg_byte(input logic [3:0] op);
      case (op)
         OP_RRMOVQ, OP_IRMOVQ, OP_RMMOVQ, OP_MRMOVQ, OP_OPQ, OP_PUSHQ, OP_POPQ: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit has_constant(input logic [3:0] op);
      case (op)
         OP_IRMOVQ, OP_RMMOVQ, OP_MRMOVQ, OP_JXX, OP_CALL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Bit 8 flags an address beyond the memory; such a byte reads as zero.
   function automatic logic [8:0] image_byte(input logic [63:0] addr);
      if (addr >= 64'(MEM_BYTES)) return 9'h100;
      return {1'b0, image_mem[addr[LOAD_ADDR_W-1:0]]};
   endfunction

   // Applies one accepted word to the shadow state. A fetch word returns 1 and the
   // decode word that the stage must show for it; a load word only writes a byte.
   function automatic bit predict_fetch(input req_word_type w, output rsp_word_type r);
      logic [63:0] pc;
      logic [63:0] cursor;
      logic [63:0] const_val;
      logic [63:0] target;
      logic [8:0]  rd;
      logic [3:0]  op;
      logic [3:0]  fn;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [1:0]  status;
      logic        fault;
      logic        load_use;
      logic        bubble;
      int          i;
      r = '0;
      if (w.cmd == CMD_LOAD) begin
         if (w.load_entry[19:8] < MEM_BYTES) image_mem[w.load_entry[19:8]] = w.load_entry[7:0];
         return 1'b0;
      end
      // A not-taken jump in memory wins over a return in writeback.
      if (w.mem_stage_opcode == OP_JXX && !w.mem_stage_cond) pc = w.mem_stage_fallthrough;
      else if (w.wb_stage_opcode == OP_RET) pc = w.wb_stage_loaded;
      else pc = next_fetch_pc;
      rd = image_byte(pc);
      fault = rd[8];
      op = rd[7:4];
      fn = rd[3:0];
      ra = NO_REG;
      rb = NO_REG;
      const_val = '0;
      cursor = pc + 64'd1;
      if (has_reg_byte(op)) begin
         rd = image_byte(cursor);
         fault |= rd[8];
         ra = rd[7:4];
         rb = rd[3:0];
         cursor += 64'd1;
      end
      if (has_constant(op)) begin
         for (i = 0; i < 8; i++) begin
            rd = image_byte(cursor + 64'(i));
            fault |= rd[8];
            const_val[8*i +: 8] = rd[7:0];
         end
         cursor += 64'd8;
      end
      // The prediction uses the opcode as read, before an address error forces a nop.
      target = (op == OP_JXX || op == OP_CALL) ? const_val : cursor;
      if (fault) begin
         status = ST_ADR;
         op = OP_NOP;
         fn = 4'd0;
      end else if (op > OP_POPQ) begin
         status = ST_INS;
      end else if (op == OP_HALT) begin
         status = ST_HALT;
      end else begin
         status = ST_OK;
      end
      // The load-use test compares ids as they are, so a destination of none matches
      // a source of none.
      load_use = (w.ex_stage_opcode == OP_MRMOVQ || w.ex_stage_opcode == OP_POPQ) &&
                 (w.ex_stage_load_dest == w.dec_src_first ||
                  w.ex_stage_load_dest == w.dec_src_second);
      bubble = (w.ex_stage_opcode == OP_JXX) && !w.ex_stage_cond;
      if (!load_use) begin
         next_fetch_pc = target;
         decode_reg = '{status, op, fn, ra, rb, const_val, cursor, target};
      end
      // A bubble overrides a held decode register.
      if (bubble) decode_reg = NOP_DECODE;
      r = '{pc, decode_reg.status, decode_reg.opcode, decode_reg.func, decode_reg.reg_a,
            decode_reg.reg_b, decode_reg.constant, decode_reg.next_pc,
            load_use, load_use, bubble};
      return 1'b1;
   endfunction

   function automatic req_word_type load_word(input logic [11:0] addr, input logic [7:0] value);
      req_word_type w;
      w = '0;
      w.cmd = CMD_LOAD;
      w.load_entry = {addr, value};
      return w;
   endfunction

   function automatic req_word_type fetch_word(
      input logic [3:0] m_op, input logic m_cnd, input logic [63:0] m_fall,
      input logic [3:0] w_op, input logic [63:0] w_val,
      input logic [3:0] e_op, input logic [3:0] e_dst, input logic e_cnd,
      input logic [3:0] src_a, input logic [3:0] src_b);
      req_word_type w;
      w = '{CMD_FETCH, 20'd0, m_op, m_cnd, m_fall, w_op, w_val, e_op, e_dst, e_cnd,
            src_a, src_b};
      return w;
   endfunction

   function automatic req_word_type random_fetch_word();
      req_word_type w;
      w.cmd = CMD_FETCH;
      w.load_entry = 20'($urandom);
      w.mem_stage_opcode = 4'($urandom);
      w.mem_stage_cond = 1'($urandom);
      w.mem_stage_fallthrough = {$urandom, $urandom};
      w.wb_stage_opcode = 4'($urandom);
      w.wb_stage_loaded = {$urandom, $urandom};
      w.ex_stage_opcode = 4'($urandom);
      w.ex_stage_load_dest = 4'($urandom);
      w.ex_stage_cond = 1'($urandom);
      w.dec_src_first = 4'($urandom);
      w.dec_src_second = 4'($urandom);
      return w;
   endfunction

   // Directed rows whose decode word is obvious carry it typed in; the register ids
   // are none, the constant zero and the control signals low except for the bubble.
   function automatic rsp_word_type plain_decode(
      input logic [63:0] addr, input logic [1:0] status, input logic [3:0] op,
      input logic [3:0] fn, input logic [63:0] next_pc, input logic bubble);
      rsp_word_type r;
      r = '{addr, status, op, fn, NO_REG, NO_REG, 64'd0, next_pc, 1'b0, 1'b0, bubble};
      return r;
   endfunction

   task automatic add_row(input req_word_type w, input bit typed = 1'b0,
                          input rsp_word_type fixed = '0);
      directed_row_type row;
      row.word = w;
      row.typed = typed;
      row.fixed = fixed;
      directed_rows.push_back(row);
   endtask

   // Offers one word, after a random gap unless the run is in its quiet tail, and
   // returns at the edge where it is accepted. The shadow state moves at that edge.
   task automatic send_word(input req_word_type w, input bit typed = 1'b0,
                            input rsp_word_type fixed = '0);
      int           gap;
      rsp_word_type guess;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (predict_fetch(w, guess)) predicted_decodes.push_back(typed ? fixed : guess);
      sent_count++;
   endtask

   // Drops valid and waits until every predicted decode word has come back.
   task automatic drain_fetches();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_decodes.size() != 0) @(posedge clock);
   endtask

   // Writes a short program of well-formed instructions from base on. Jumps and calls
   // mostly aim at one of its own instructions so that the predicted PC stays inside.
   task automatic write_program(input int base, input int count);
      logic [3:0]  ops [$];
      logic [7:0]  bytes [$];
      logic [63:0] at;
      logic [63:0] value;
      logic [3:0]  op;
      int          i;
      int          j;
      at = 64'(base);
      program_entries.delete();
      for (i = 0; i < count; i++) begin
         // Now and then an invalid opcode slips into the program.
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
         ops.push_back(op);
         program_entries.push_back(at);
         at += 64'd1 + (has_reg_byte(op) ? 64'd1 : 64'd0) + (has_constant(op) ? 64'd8 : 64'd0);
      end
      for (i = 0; i < count; i++) begin
         bytes.delete();
         bytes.push_back({ops[i], 4'($urandom)});
         if (has_reg_byte(ops[i])) bytes.push_back(8'($urandom));
         if (has_constant(ops[i])) begin
            if ((ops[i] == OP_JXX || ops[i] == OP_CALL) && $urandom_range(0, 4) != 0)
               value = program_entries[$urandom_range(0, count - 1)];
            else
               value = {$urandom, $urandom};
            for (j = 0; j < 8; j++) bytes.push_back(value[8*j +: 8]);
         end
         // Bytes that would lie past the end of the memory cannot be written.
         for (j = 0; j < bytes.size(); j++) begin
            if (program_entries[i] + 64'(j) < 64'(MEM_BYTES))
               send_word(load_word(12'(program_entries[i] + 64'(j)), bytes[j]));
         end
      end
   endtask

   // Runs fetch cycles over the program: the first one jumps in through a return,
   // the rest are mostly quiet with stalls, bubbles and redirects mixed in.
   task automatic run_program(input int cycles);
      req_word_type w;
      int           i;
      int           roll;
      for (i = 0; i < cycles; i++) begin
         w = random_fetch_word();
         if (w.mem_stage_opcode == OP_JXX) w.mem_stage_cond = 1'b1;
         if (w.wb_stage_opcode == OP_RET) w.wb_stage_opcode = OP_NOP;
         if (w.ex_stage_opcode == OP_JXX) w.ex_stage_cond = 1'b1;
         if (w.ex_stage_opcode == OP_MRMOVQ || w.ex_stage_opcode == OP_POPQ)
            w.ex_stage_opcode = OP_OPQ;
         roll = (i == 0) ? -1 : $urandom_range(0, 15);
         if (roll < 0) begin
            w.wb_stage_opcode = OP_RET;
            w.wb_stage_loaded = program_entries[0];
         end else if (roll == 0) begin
            w.ex_stage_opcode = $urandom_range(0, 1) ? OP_MRMOVQ : OP_POPQ;
            w.ex_stage_load_dest = $urandom_range(0, 1) ? w.dec_src_first : w.dec_src_second;
         end else if (roll == 1) begin
            w.ex_stage_opcode = OP_JXX;
            w.ex_stage_cond = 1'b0;
         end else if (roll == 2) begin
            w.mem_stage_opcode = OP_JXX;
            w.mem_stage_cond = 1'b0;
            w.mem_stage_fallthrough = program_entries[$urandom_range(0, program_entries.size() - 1)];
         end else if (roll == 3) begin
            w.wb_stage_opcode = OP_RET;
            w.wb_stage_loaded = program_entries[$urandom_range(0, program_entries.size() - 1)];
         end
         send_word(w);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Every accepted response word is held against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (predicted_decodes.size() == 0) begin
            $display("%0t: response word with none expected, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            oldest = predicted_decodes.pop_front();
            compare_field("fetch_addr", oldest.fetch_addr, rsp_data.fetch_addr);
            compare_field("dreg_status", 64'(oldest.dreg_status), 64'(rsp_data.dreg_status));
            compare_field("dreg_opcode", 64'(oldest.dreg_opcode), 64'(rsp_data.dreg_opcode));
            compare_field("dreg_func", 64'(oldest.dreg_func), 64'(rsp_data.dreg_func));
            compare_field("dreg_reg_a", 64'(oldest.dreg_reg_a), 64'(rsp_data.dreg_reg_a));
            compare_field("dreg_reg_b", 64'(oldest.dreg_reg_b), 64'(rsp_data.dreg_reg_b));
            compare_field("dreg_constant", oldest.dreg_constant, rsp_data.dreg_constant);
            compare_field("dreg_next_pc", oldest.dreg_next_pc, rsp_data.dreg_next_pc);
            compare_field("fetch_stall", 64'(oldest.fetch_stall), 64'(rsp_data.fetch_stall));
            compare_field("decode_stall", 64'(oldest.decode_stall), 64'(rsp_data.decode_stall));
            compare_field("decode_bubble", 64'(oldest.decode_bubble),
                          64'(rsp_data.decode_bubble));
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none in the tail.
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_pipelined_isa_fetch_stage_unit: done, errors");
      $finish;
   end

   initial begin
      int i;
      int base;
      bit hold_done;
      bit drain_done;
      hold_done = 1'b0;
      drain_done = 1'b0;
      for (i = 0; i < MEM_BYTES; i++) image_mem[i] = 8'h00;
      next_fetch_pc = '0;
      decode_reg = NOP_DECODE;

      // Fetch from the cleared memory at PC zero: a halt with next PC one.
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_HALT, '0, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0),
              1'b1, plain_decode('0, ST_HALT, OP_HALT, 4'd0, 64'd1, 1'b0));
      // Not-taken jump to the top address: out of range, and the next PC wraps to zero.
      add_row(fetch_word(OP_JXX, 1'b0, '1, OP_HALT, '0, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0),
              1'b1, plain_decode('1, ST_ADR, OP_NOP, 4'd0, 64'd0, 1'b0));
      // Return to the last byte of memory.
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_RET, 64'd4095, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0),
              1'b1, plain_decode(64'd4095, ST_HALT, OP_HALT, 4'd0, 64'd4096, 1'b0));
      // Mispredict bubble in execute hides the address error fetched at 4096.
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_HALT, '0, OP_JXX, 4'd0, 1'b0, 4'd0, 4'd0),
              1'b1, plain_decode(64'd4096, ST_OK, OP_NOP, 4'd0, 64'd0, 1'b1));
      // All-ones load word: byte 0xFF at the last address, an invalid opcode.
      add_row(load_word(12'hFFF, 8'hFF));
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_RET, 64'd4095, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0),
              1'b1, plain_decode(64'd4095, ST_INS, 4'hF, 4'hF, 64'd4096, 1'b0));
      add_row(load_word(12'h000, 8'h00));
      // An irmovq whose constant runs past the end of memory.
      add_row(load_word(12'd4090, {OP_IRMOVQ, 4'h0}));
      add_row(load_word(12'd4091, 8'h12));
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_RET, 64'd4090, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0));
      // Not-taken jump and return together: the jump's fall-through wins.
      add_row(fetch_word(OP_JXX, 1'b0, '0, OP_RET, 64'd4095, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0));
      // A jump whose target feeds the predicted PC.
      add_row(load_word(12'h100, {OP_JXX, 4'h3}));
      add_row(load_word(12'h101, 8'h40));
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_RET, 64'h100, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0));
      add_row(load_word(12'h040, {OP_CALL, 4'h0}));
      // Load-use with no register on both sides still stalls.
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_HALT, '0, OP_MRMOVQ, NO_REG, 1'b0, NO_REG, 4'd0));
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_HALT, '0, OP_POPQ, 4'd3, 1'b0, 4'd0, 4'd3));
      add_row(fetch_word(OP_HALT, 1'b0, '0, OP_HALT, '0, OP_MRMOVQ, 4'd4, 1'b0, 4'd5, 4'd6));
      // Taken jump in memory does not redirect, so the return does.
      add_row(fetch_word(OP_JXX, 1'b1, '1, OP_RET, 64'h100, OP_HALT, 4'd0, 1'b0, 4'd0, 4'd0));
      add_row(fetch_word(OP_NOP, 1'b0, '0, OP_NOP, '0, OP_NOP, 4'd0, 1'b0, 4'd0, 4'd0));
      // Every field at its top value.
      add_row('1);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].fixed);
      drain_fetches();

      // Random part: mostly a program written and then run, sometimes raw noise words
      // of either kind that scribble over memory and redirect anywhere.
      while (sent_count < TOTAL_WORDS) begin
         if (!hold_done && sent_count > HOLD_AT) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && sent_count > DRAIN_AT) begin
            drain_fetches();
            drain_done = 1'b1;
         end
         if (sent_count > QUIET_AT) quiet_tail = 1'b1;
         if ($urandom_range(0, 6) != 0) begin
            base = ($urandom_range(0, 9) == 0) ? $urandom_range(4060, 4095)
                                               : $urandom_range(0, 3900);
            write_program(base, $urandom_range(3, 8));
            run_program($urandom_range(10, 30));
         end else begin
            repeat ($urandom_range(5, 20)) begin
               req_data_noise: begin
                  req_word_type w;
                  w = random_fetch_word();
                  w.cmd = 1'($urandom);
                  send_word(w);
               end
            end
         end
      end

      drain_fetches();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb_pipelined_isa_fetch_stage_unit: done, clean");
      else
         $display("tb_pipelined_isa_fetch_stage_unit: done, errors");
      $finish;
   end

endmodule
